// File: hw/rtl/fmg_pkg.sv
// shared types and constants for the fuzzy membership grade pipeline
package fmg_pkg;

    // fixed field widths
    localparam int PT_W       = 16;
    localparam int GR_W       = 9;
    localparam int SET_W      = 2;
    localparam int MAX_POINTS = 4;
    localparam int SET_COUNT  = 3;
    localparam int BPS_W      = PT_W * MAX_POINTS;
    localparam int GRS_W      = GR_W * MAX_POINTS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PROD_W     = PT_W + GR_W;
    localparam int QUO_W      = GR_W;

    // set codes
    localparam logic [SET_W-1:0] SET_LOW  = 2'd0;
    localparam logic [SET_W-1:0] SET_MED  = 2'd1;
    localparam logic [SET_W-1:0] SET_HIGH = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BPS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MED_BPS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GRS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MED_GRS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GRS = 3'd5;

    // default curves after reset
    localparam logic [BPS_W-1:0] RST_LOW_BPS  = 64'd360293467798110208;
    localparam logic [BPS_W-1:0] RST_MED_BPS  = 64'd1080874905769083648;
    localparam logic [BPS_W-1:0] RST_HIGH_BPS = 64'd3602896194738588160;
    localparam logic [GRS_W-1:0] RST_LOW_GRS  = 36'd131328;
    localparam logic [GRS_W-1:0] RST_MED_GRS  = 36'd67239936;
    localparam logic [GRS_W-1:0] RST_HIGH_GRS = 36'd34426847232;

    // one set's curve
    typedef struct packed {
        logic [MAX_POINTS-1:0][PT_W-1:0] pts;
        logic [MAX_POINTS-1:0][GR_W-1:0] grs;
    } t_curve;

    typedef t_curve [SET_COUNT-1:0] t_curve_bank;

    // after set selection
    typedef struct packed {
        logic [PT_W-1:0]  x;
        logic [SET_W-1:0] set;
        logic             oor;
        t_curve           curve;
    } t_sel_item;

    // after segment search
    typedef struct packed {
        logic [SET_W-1:0] set;
        logic             oor;
        logic [GR_W-1:0]  base;
        logic [GR_W-1:0]  diff;
        logic [PT_W-1:0]  delta;
        logic [PT_W-1:0]  span;
    } t_seg_item;

    // after the multiply
    typedef struct packed {
        logic [SET_W-1:0]  set;
        logic              oor;
        logic [GR_W-1:0]   base;
        logic [PT_W-1:0]   span;
        logic [PROD_W-1:0] prod;
    } t_prod_item;

    // inside the divider
    typedef struct packed {
        logic [SET_W-1:0]  set;
        logic              oor;
        logic [GR_W-1:0]   base;
        logic [PT_W-1:0]   span;
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } t_div_item;

endpackage

// File: hw/rtl/fmg_cfg_regs.sv
// configuration registers holding the three set curves
module fmg_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [fmg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fmg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output fmg_pkg::t_curve_bank              o_bank
);
    import fmg_pkg::*;

    logic [BPS_W-1:0] r_bps [SET_COUNT];
    logic [GRS_W-1:0] r_grs [SET_COUNT];

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps[0] <= RST_LOW_BPS;
            r_bps[1] <= RST_MED_BPS;
            r_bps[2] <= RST_HIGH_BPS;
            r_grs[0] <= RST_LOW_GRS;
            r_grs[1] <= RST_MED_GRS;
            r_grs[2] <= RST_HIGH_GRS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LOW_BPS:  r_bps[0] <= i_cfg_data;
                REG_MED_BPS:  r_bps[1] <= i_cfg_data;
                REG_HIGH_BPS: r_bps[2] <= i_cfg_data;
                REG_LOW_GRS:  r_grs[0] <= i_cfg_data[GRS_W-1:0];
                REG_MED_GRS:  r_grs[1] <= i_cfg_data[GRS_W-1:0];
                REG_HIGH_GRS: r_grs[2] <= i_cfg_data[GRS_W-1:0];
                default: ;
            endcase
        end
    end

    // pack into curves
    always_comb begin
        for (int s = 0; s < SET_COUNT; s++) begin
            o_bank[s].pts = r_bps[s];
            o_bank[s].grs = r_grs[s];
        end
    end

endmodule

// File: hw/rtl/fmg_select.sv
// first pipeline stage: picks the fuzzy set and its curve
module fmg_select #(
    parameter int POINTS_PER_SET = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fmg_pkg::t_curve_bank       i_bank,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [fmg_pkg::PT_W-1:0]   i_x,
    output logic                       o_valid,
    input  logic                       i_ready,
    output fmg_pkg::t_sel_item         o_item
);
    import fmg_pkg::*;

    localparam logic [1:0] LAST_IDX = 2'(POINTS_PER_SET - 1);

    logic      in_low;
    logic      in_med;
    logic      in_high;
    t_sel_item n_item;
    t_sel_item r_item;
    logic      r_valid;

    // first match on open ranges, high set open above
    assign in_low  = (i_x > i_bank[0].pts[0]) && (i_x < i_bank[0].pts[LAST_IDX]);
    assign in_med  = (i_x > i_bank[1].pts[0]) && (i_x < i_bank[1].pts[LAST_IDX]);
    assign in_high = (i_x > i_bank[2].pts[0]);

    always_comb begin
        n_item.x     = i_x;
        n_item.oor   = 1'b0;
        n_item.set   = SET_LOW;
        n_item.curve = i_bank[0];
        if (in_low) begin
            n_item.set = SET_LOW;
        end else if (in_med) begin
            n_item.set   = SET_MED;
            n_item.curve = i_bank[1];
        end else if (in_high) begin
            n_item.set   = SET_HIGH;
            n_item.curve = i_bank[2];
        end else begin
            n_item.oor = 1'b1;
        end
    end

    // stage register
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/fmg_segment.sv
// second pipeline stage: finds the curve segment and the interpolation operands
module fmg_segment #(
    parameter int POINTS_PER_SET = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fmg_pkg::t_sel_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fmg_pkg::t_seg_item   o_item
);
    import fmg_pkg::*;

    localparam logic [1:0] LAST_IDX = 2'(POINTS_PER_SET - 1);

    logic            hit;
    logic [PT_W-1:0] x;
    t_curve          c;
    t_seg_item       n_item;
    t_seg_item       r_item;
    logic            r_valid;

    assign x = i_item.x;
    assign c = i_item.curve;

    // scan segments in order; exact point wins before the segment above it
    always_comb begin
        n_item.set   = i_item.set;
        n_item.oor   = i_item.oor;
        n_item.base  = c.grs[LAST_IDX];
        n_item.diff  = '0;
        n_item.delta = '0;
        n_item.span  = PT_W'(1);
        hit          = 1'b0;
        if (x < c.pts[0]) begin
            n_item.base = c.grs[0];
        end else begin
            for (int k = 0; k < POINTS_PER_SET - 1; k++) begin
                if (!hit) begin
                    if (x == c.pts[k]) begin
                        hit         = 1'b1;
                        n_item.base = c.grs[k];
                    end else if (x > c.pts[k] && x < c.pts[k+1]) begin
                        hit         = 1'b1;
                        n_item.span = c.pts[k+1] - c.pts[k];
                        if (c.grs[k] < c.grs[k+1]) begin
                            n_item.base  = c.grs[k];
                            n_item.diff  = c.grs[k+1] - c.grs[k];
                            n_item.delta = x - c.pts[k];
                        end else if (c.grs[k] > c.grs[k+1]) begin
                            n_item.base  = c.grs[k+1];
                            n_item.diff  = c.grs[k] - c.grs[k+1];
                            n_item.delta = c.pts[k+1] - x;
                        end else begin
                            n_item.base = c.grs[k];
                        end
                    end
                end
            end
        end
    end

    // stage register
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/fmg_interp.sv
// multiply, one-bit-per-stage restoring divide, and final grade add
module fmg_interp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  fmg_pkg::t_seg_item         i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [fmg_pkg::GR_W-1:0]   o_membership,
    output logic [fmg_pkg::SET_W-1:0]  o_chosen_set,
    output logic                       o_out_of_range
);
    import fmg_pkg::*;

    t_prod_item       r_pm;
    logic             r_pm_v;
    logic             rdy_pm;
    t_div_item        r_dv [QUO_W];
    logic [QUO_W-1:0] r_dv_v;
    logic [QUO_W-1:0] rdy_dv;
    t_div_item        dv_in [QUO_W];
    logic [QUO_W-1:0] dv_in_v;
    logic             rdy_o;
    logic             r_o_v;
    logic [GR_W-1:0]  r_membership;
    logic [SET_W-1:0] r_chosen_set;
    logic             r_out_of_range;
    logic [GR_W:0]    sum;

    // ready chain, bubbles collapse
    assign rdy_o  = !r_o_v || i_ready;
    assign rdy_dv[QUO_W-1] = !r_dv_v[QUO_W-1] || rdy_o;
    generate
        for (genvar s = 0; s < QUO_W - 1; s++) begin : g_rdy
            assign rdy_dv[s] = !r_dv_v[s] || rdy_dv[s+1];
        end
    endgenerate
    assign rdy_pm  = !r_pm_v || rdy_dv[0];
    assign o_ready = rdy_pm;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm_v <= 1'b0;
        end else if (rdy_pm) begin
            r_pm_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_pm && i_valid) begin
            r_pm.set  <= i_item.set;
            r_pm.oor  <= i_item.oor;
            r_pm.base <= i_item.base;
            r_pm.span <= i_item.span;
            r_pm.prod <= PROD_W'(i_item.delta) * PROD_W'(i_item.diff);
        end
    end

    // divider input of stage zero
    always_comb begin
        dv_in[0].set  = r_pm.set;
        dv_in[0].oor  = r_pm.oor;
        dv_in[0].base = r_pm.base;
        dv_in[0].span = r_pm.span;
        dv_in[0].rem  = r_pm.prod;
        dv_in[0].quo  = '0;
        dv_in_v[0]    = r_pm_v;
    end

    // divide stages, most significant quotient bit first
    generate
        for (genvar s = 0; s < QUO_W; s++) begin : g_div
            localparam int BIT = QUO_W - 1 - s;
            logic [PROD_W-1:0] trial;
            t_div_item         n_dv;

            if (s > 0) begin : g_link
                assign dv_in[s]   = r_dv[s-1];
                assign dv_in_v[s] = r_dv_v[s-1];
            end

            assign trial = PROD_W'(dv_in[s].span) << BIT;

            always_comb begin
                n_dv = dv_in[s];
                if (dv_in[s].rem >= trial) begin
                    n_dv.rem      = dv_in[s].rem - trial;
                    n_dv.quo[BIT] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[s] <= 1'b0;
                end else if (rdy_dv[s]) begin
                    r_dv_v[s] <= dv_in_v[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy_dv[s] && dv_in_v[s]) begin
                    r_dv[s] <= n_dv;
                end
            end
        end
    endgenerate

    // output register: grade is base plus quotient
    assign sum = {1'b0, r_dv[QUO_W-1].base} + {1'b0, r_dv[QUO_W-1].quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (rdy_o) begin
            r_o_v <= r_dv_v[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o && r_dv_v[QUO_W-1]) begin
            r_membership   <= sum[GR_W-1:0];
            r_chosen_set   <= r_dv[QUO_W-1].set;
            r_out_of_range <= r_dv[QUO_W-1].oor;
        end
    end

    assign o_valid        = r_o_v;
    assign o_membership   = r_membership;
    assign o_chosen_set   = r_chosen_set;
    assign o_out_of_range = r_out_of_range;

endmodule

// File: hw/rtl/fuzzy_membership_grade.sv
// top level of the trapezoidal fuzzy membership grade pipeline
//
// Input channel (i_in_valid/o_in_ready) carries one unsigned Q8.8 crisp value
// per transfer. Output channel (o_out_valid/i_out_ready) returns one result per
// input: the membership grade (256 is 1.0), the chosen set and an out of range
// flag. The config channel (i_cfg_valid/o_cfg_ready) writes the breakpoints
// and grades of the low, medium and high sets; it is always ready and should
// only be written while the pipeline is empty.
// Each item passes through set select, segment search, multiply, nine divider
// stages (one quotient bit each, set by the 25-bit compare and subtract per
// stage) and the output register.
// Throughput is one item per cycle while the receiver does not stall.
// Reset clears every valid bit and loads the default low, medium and high
// curves. When the receiver stalls, each stage holds its item, empty stages
// still fill, and o_in_ready drops only once all stages are occupied.
module fuzzy_membership_grade #(
    parameter int POINTS_PER_SET = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fmg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fmg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fmg_pkg::PT_W-1:0]          i_crisp_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fmg_pkg::GR_W-1:0]          o_membership,
    output logic [fmg_pkg::SET_W-1:0]         o_chosen_set,
    output logic                              o_out_of_range
);
    import fmg_pkg::*;

    t_curve_bank bank;
    logic        sel_valid;
    logic        sel_ready;
    t_sel_item   sel_item;
    logic        seg_valid;
    logic        seg_ready;
    t_seg_item   seg_item;

    assign o_cfg_ready = 1'b1;

    // curve registers
    fmg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bank      (bank)
    );

    // set selection
    fmg_select #(
        .POINTS_PER_SET (POINTS_PER_SET)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bank  (bank),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (i_crisp_value),
        .o_valid (sel_valid),
        .i_ready (sel_ready),
        .o_item  (sel_item)
    );

    // segment search
    fmg_segment #(
        .POINTS_PER_SET (POINTS_PER_SET)
    ) u_segment (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sel_valid),
        .o_ready (sel_ready),
        .i_item  (sel_item),
        .o_valid (seg_valid),
        .i_ready (seg_ready),
        .o_item  (seg_item)
    );

    // interpolation
    fmg_interp u_interp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (seg_valid),
        .o_ready        (seg_ready),
        .i_item         (seg_item),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_membership   (o_membership),
        .o_chosen_set   (o_chosen_set),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// File: tb/tb_fuzzy_membership_grade.sv
// self-checking testbench for the fuzzy membership grade pipeline, random curves and stalls
module tb_fuzzy_membership_grade;
    import fmg_pkg::*;

    localparam int POINTS      = 4;
    localparam int LAST_LSB    = PT_W * (POINTS - 1);
    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CYCLES = 120;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [GR_W-1:0]  grade;
        logic [SET_W-1:0] chosen;
        logic             oor;
    } t_grade_result;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [PT_W-1:0]       crisp     = '0;
    logic                  out_ready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [GR_W-1:0]       o_membership;
    logic [SET_W-1:0]      o_chosen_set;
    logic                  o_out_of_range;

    // shadow copy of the curve registers, indexed by set code
    logic [BPS_W-1:0] set_points [SET_COUNT];
    logic [GRS_W-1:0] set_grades [SET_COUNT];

    t_grade_result pending_grades [$];
    t_grade_result due;

    bit jitter_on = 1'b1;
    bit hold_req  = 1'b0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 0;
    int n_oor      = 0;
    int seen_sets [SET_COUNT] = '{0, 0, 0};

    fuzzy_membership_grade #(.POINTS_PER_SET(POINTS)) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_crisp_value  (crisp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_membership   (o_membership),
        .o_chosen_set   (o_chosen_set),
        .o_out_of_range (o_out_of_range)
    );

    always #5 clk = ~clk;

    function automatic logic [BPS_W-1:0] pack_points(input logic [PT_W-1:0] p0, p1, p2, p3);
        return {p3, p2, p1, p0};
    endfunction

    function automatic logic [GRS_W-1:0] pack_grades(input logic [GR_W-1:0] g0, g1, g2, g3);
        return {g3, g2, g1, g0};
    endfunction

    // piecewise-linear grade on one curve, truncating interpolation
    function automatic logic [GR_W-1:0] curve_grade(input logic [PT_W-1:0] x,
                                                    input logic [BPS_W-1:0] pts,
                                                    input logic [GRS_W-1:0] grs);
        logic [PT_W-1:0] b0, b1;
        logic [GR_W-1:0] g0, g1, r;
        logic [63:0]     q;
        bit              found;
        r = grs[GR_W*(POINTS-1) +: GR_W];
        found = (x < pts[PT_W-1:0]);
        if (found) r = grs[GR_W-1:0];
        for (int k = 0; k < POINTS - 1; k++) begin
            if (!found) begin
                b0 = pts[PT_W*k +: PT_W];
                b1 = pts[PT_W*(k+1) +: PT_W];
                g0 = grs[GR_W*k +: GR_W];
                g1 = grs[GR_W*(k+1) +: GR_W];
                // lowest matching breakpoint wins
                if (x == b0) begin
                    r = g0;
                    found = 1'b1;
                end else if (x > b0 && x < b1) begin
                    found = 1'b1;
                    if (g0 < g1) begin
                        q = (64'(x - b0) * 64'(g1 - g0)) / 64'(b1 - b0);
                        r = g0 + q[GR_W-1:0];
                    end else if (g0 > g1) begin
                        q = (64'(b1 - x) * 64'(g0 - g1)) / 64'(b1 - b0);
                        r = g1 + q[GR_W-1:0];
                    end else begin
                        r = g0;
                    end
                end
            end
        end
        return r;
    endfunction

    // first match on open ranges, low set as fallback
    function automatic t_grade_result predict_grade(input logic [PT_W-1:0] x);
        t_grade_result r;
        r.oor = 1'b0;
        if (x > set_points[SET_LOW][PT_W-1:0] && x < set_points[SET_LOW][LAST_LSB +: PT_W])
            r.chosen = SET_LOW;
        else if (x > set_points[SET_MED][PT_W-1:0] && x < set_points[SET_MED][LAST_LSB +: PT_W])
            r.chosen = SET_MED;
        else if (x > set_points[SET_HIGH][PT_W-1:0])
            r.chosen = SET_HIGH;
        else begin
            r.chosen = SET_LOW;
            r.oor = 1'b1;
        end
        r.grade = curve_grade(x, set_points[r.chosen], set_grades[r.chosen]);
        return r;
    endfunction

    // mostly values near a breakpoint, some extremes, some anywhere
    function automatic logic [PT_W-1:0] pick_crisp();
        int roll, s, k;
        logic [PT_W-1:0] base;
        roll = $urandom_range(99);
        if (roll < 70) begin
            s = $urandom_range(SET_COUNT - 1);
            k = $urandom_range(POINTS - 1);
            base = set_points[s][PT_W*k +: PT_W];
            return base + PT_W'($urandom_range(4)) - PT_W'(2);
        end
        if (roll < 76) return ($urandom_range(1) != 0) ? {PT_W{1'b1}} : {PT_W{1'b0}};
        return PT_W'($urandom);
    endfunction

    // one crisp value transfer, at times with a random gap before it
    task automatic send_crisp(input logic [PT_W-1:0] value);
        if (jitter_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        crisp    <= value;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        pending_grades.push_back(predict_grade(value));
        n_sent++;
    endtask

    // one register transfer, shadow copy follows it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LOW_BPS:  set_points[SET_LOW]  = data;
            REG_MED_BPS:  set_points[SET_MED]  = data;
            REG_HIGH_BPS: set_points[SET_HIGH] = data;
            REG_LOW_GRS:  set_grades[SET_LOW]  = data[GRS_W-1:0];
            REG_MED_GRS:  set_grades[SET_MED]  = data[GRS_W-1:0];
            REG_HIGH_GRS: set_grades[SET_HIGH] = data[GRS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grades.size() != 0) @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [CFG_DATA_W-1:0] data);
        write_reg(REG_LOW_BPS, data);
        write_reg(REG_MED_BPS, data);
        write_reg(REG_HIGH_BPS, data);
        write_reg(REG_LOW_GRS, data);
        write_reg(REG_MED_GRS, data);
        write_reg(REG_HIGH_GRS, data);
    endtask

    // random curves: sorted wide, sorted narrow, with a duplicate, or unordered
    task automatic load_random_curves();
        logic [PT_W-1:0]       p [POINTS];
        logic [PT_W-1:0]       t;
        logic [GRS_W-1:0]      g;
        logic [CFG_DATA_W-1:0] data;
        int                    mode, dup;
        for (int s = 0; s < SET_COUNT; s++) begin
            mode = $urandom_range(3);
            t = PT_W'($urandom_range(16'hF000));
            for (int k = 0; k < POINTS; k++)
                p[k] = (mode == 1) ? t + PT_W'($urandom_range(255)) : PT_W'($urandom);
            if (mode != 3) begin
                for (int i = 0; i < POINTS - 1; i++)
                    for (int j = 0; j < POINTS - 1 - i; j++)
                        if (p[j] > p[j+1]) begin
                            t = p[j];
                            p[j] = p[j+1];
                            p[j+1] = t;
                        end
            end
            if (mode == 2) begin
                dup = $urandom_range(POINTS - 2);
                p[dup+1] = p[dup];
            end
            for (int k = 0; k < POINTS; k++) begin
                case ($urandom_range(3))
                    0: g[GR_W*k +: GR_W] = '0;
                    1: g[GR_W*k +: GR_W] = GR_W'(256);
                    2: g[GR_W*k +: GR_W] = {GR_W{1'b1}};
                    default: g[GR_W*k +: GR_W] = GR_W'($urandom_range(511));
                endcase
            end
            data = {$urandom, $urandom};
            data[GRS_W-1:0] = g;
            write_reg((s == 0) ? REG_LOW_BPS : (s == 1) ? REG_MED_BPS : REG_HIGH_BPS,
                      pack_points(p[0], p[1], p[2], p[3]));
            write_reg((s == 0) ? REG_LOW_GRS : (s == 1) ? REG_MED_GRS : REG_HIGH_GRS, data);
        end
        write_reg(($urandom_range(1) != 0) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
    endtask

    // curves after reset, values on and around every breakpoint
    task automatic test_default_curves();
        logic [PT_W-1:0] picks [11];
        set_points[SET_LOW]  = pack_points(16'h0000, 16'h0300, 16'h0500, 16'h0500);
        set_points[SET_MED]  = pack_points(16'h0300, 16'h0500, 16'h0A00, 16'h0F00);
        set_points[SET_HIGH] = pack_points(16'h0A00, 16'h0A00, 16'h0F00, 16'h3200);
        set_grades[SET_LOW]  = pack_grades(9'd256, 9'd256, 9'd0, 9'd0);
        set_grades[SET_MED]  = pack_grades(9'd0, 9'd256, 9'd256, 9'd0);
        set_grades[SET_HIGH] = pack_grades(9'd0, 9'd0, 9'd256, 9'd256);
        n_settings++;
        picks = '{16'h0000, 16'h0001, 16'h02FF, 16'h0300, 16'h0500, 16'h0501,
                  16'h0A00, 16'h0A01, 16'h0F00, 16'h3201, 16'hFFFF};
        foreach (picks[i]) send_crisp(picks[i]);
        wait_drained();
    endtask

    // duplicate and unordered breakpoints, grades above one, field extremes
    task automatic test_corner_curves();
        logic [PT_W-1:0] edge_picks [7];
        logic [PT_W-1:0] mixed_picks [9];
        write_reg(REG_LOW_BPS, pack_points(16'h0000, 16'h0000, 16'h8000, 16'hFFFF));
        write_reg(REG_LOW_GRS, {28'hFFFFFFF, pack_grades(9'd511, 9'd0, 9'd300, 9'd256)});
        write_reg(REG_MED_BPS, {CFG_DATA_W{1'b1}});
        write_reg(REG_MED_GRS, {CFG_DATA_W{1'b1}});
        write_reg(REG_HIGH_BPS, {CFG_DATA_W{1'b1}});
        write_reg(REG_HIGH_GRS, '0);
        write_reg(REG_SPARE_6, {CFG_DATA_W{1'b1}});
        write_reg(REG_SPARE_7, '0);
        n_settings++;
        edge_picks = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFE, 16'hFFFF};
        foreach (edge_picks[i]) send_crisp(edge_picks[i]);
        wait_drained();

        write_reg(REG_LOW_BPS, pack_points(16'h0100, 16'h0400, 16'h0200, 16'h0300));
        write_reg(REG_LOW_GRS, {28'h5A5A5A5, pack_grades(9'd0, 9'd256, 9'd100, 9'd400)});
        write_reg(REG_MED_BPS, pack_points(16'h0050, 16'h0800, 16'h0600, 16'h0700));
        write_reg(REG_MED_GRS, {28'h0, pack_grades(9'd256, 9'd0, 9'd511, 9'd1)});
        write_reg(REG_HIGH_BPS, pack_points(16'h0000, 16'h9000, 16'h8000, 16'hA000));
        write_reg(REG_HIGH_GRS, {28'h0, pack_grades(9'd10, 9'd300, 9'd20, 9'd0)});
        n_settings++;
        mixed_picks = '{16'h0000, 16'h0150, 16'h0250, 16'h02FF, 16'h0300,
                        16'h0650, 16'h0800, 16'h8800, 16'h9000};
        foreach (mixed_picks[i]) send_crisp(mixed_picks[i]);
        wait_drained();
    endtask

    // phases of random curves, starting with all zeros and all ones
    task automatic test_random_curves();
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            if (phase == 0) write_all_regs('0);
            else if (phase == 1) write_all_regs({CFG_DATA_W{1'b1}});
            else load_random_curves();
            n_settings++;
            repeat (100) send_crisp(pick_crisp());
        end
        wait_drained();
    endtask

    // receiver holds off long enough for the pipeline to fill and push back
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (60) send_crisp(pick_crisp());
        wait_drained();
    endtask

    // back to back transfers with no idling on either side
    task automatic test_burst();
        jitter_on = 1'b0;
        repeat (250) send_crisp(pick_crisp());
        wait_drained();
        jitter_on = 1'b1;
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_pause_resume();
        load_random_curves();
        n_settings++;
        repeat (3) begin
            repeat (40) send_crisp(pick_crisp());
            wait_drained();
        end
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else begin
                out_ready <= !(jitter_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // compare each result transfer against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_grades.size() == 0) begin
                $display("%0t: result with nothing expected: grade %0d set %0d oor %0b",
                         $time, o_membership, o_chosen_set, o_out_of_range);
                n_errors++;
            end else begin
                due = pending_grades.pop_front();
                if (o_membership !== due.grade) begin
                    $display("%0t: membership expected %0d actual %0d",
                             $time, due.grade, o_membership);
                    n_errors++;
                end
                if (o_chosen_set !== due.chosen) begin
                    $display("%0t: chosen_set expected %0d actual %0d",
                             $time, due.chosen, o_chosen_set);
                    n_errors++;
                end
                if (o_out_of_range !== due.oor) begin
                    $display("%0t: out_of_range expected %0b actual %0b",
                             $time, due.oor, o_out_of_range);
                    n_errors++;
                end
                n_checked++;
                if (due.oor) n_oor++;
                else seen_sets[due.chosen]++;
            end
        end
    end

    // test sequence
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_default_curves();
        test_corner_curves();
        test_random_curves();
        test_backpressure();
        test_burst();
        test_pause_resume();
        wait_drained();
        repeat (20) @(posedge clk);
        $display("checked %0d of %0d crisp values under %0d curve settings, stalls on both sides",
                 n_checked, n_sent, n_settings);
        $display("results by set: low %0d, medium %0d, high %0d, out of range %0d",
                 seen_sets[SET_LOW], seen_sets[SET_MED], seen_sets[SET_HIGH], n_oor);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("%0t: run timed out with %0d results outstanding", $time, pending_grades.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: fuzzy_membership_grade.f
hw/rtl/fmg_pkg.sv
hw/rtl/fmg_cfg_regs.sv
hw/rtl/fmg_select.sv
hw/rtl/fmg_segment.sv
hw/rtl/fmg_interp.sv
hw/rtl/fuzzy_membership_grade.sv
tb/tb_fuzzy_membership_grade.sv
